// ===== src/msrp_pkg.sv =====
package msrp_pkg;

	// Ramp period in ticks and width of the elapsed-tick timer.
	localparam int RAMP_PERIOD = 25;
	localparam int TIMER_BITS  = 32;
	localparam int RUN_TIME_W  = 32;
	localparam int CMP_W       = (TIMER_BITS > RUN_TIME_W) ? TIMER_BITS : RUN_TIME_W;

	localparam logic [14:0] SPEED_MAX = 15'd25600;

	localparam logic [1:0] HEAD_CW  = 2'd1;
	localparam logic [1:0] HEAD_CCW = 2'd2;
	localparam logic [1:0] COIL_OFF = 2'd0;

	typedef enum logic [2:0] {
		KIND_TICK      = 3'd0,
		KIND_START     = 3'd1,
		KIND_STOP      = 3'd2,
		KIND_NEW_SPEED = 3'd3,
		KIND_NEW_STEP  = 3'd4,
		KIND_NEW_DIR   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		REG_START_DIRECTION = 3'd0,
		REG_TARGET_SPEED    = 3'd1,
		REG_RAMP_STEP       = 3'd2,
		REG_TIMED_RUN       = 3'd3,
		REG_RUN_TIME_MS     = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [14:0] value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] speed_now;
		logic [14:0]        duty;
		logic [1:0]         coil_polarity;
		logic               running;
		logic               on_target;
		logic               timed_active;
	} result_t;

	function automatic logic [14:0] clamp_speed(input logic [14:0] v);
		return (v > SPEED_MAX) ? SPEED_MAX : v;
	endfunction

	function automatic logic signed [15:0] signed_by_heading(input logic [1:0] head,
			input logic [14:0] mag);
		logic signed [15:0] s;
		s = signed'({1'b0, mag});
		if (head == HEAD_CW) begin
			return s;
		end else if (head == HEAD_CCW) begin
			return -s;
		end
		return 16'sd0;
	endfunction

	function automatic logic [14:0] magnitude(input logic signed [15:0] v);
		logic signed [15:0] neg;
		neg = -v;
		return v[15] ? neg[14:0] : v[14:0];
	endfunction

	function automatic logic [1:0] coils_for(input logic [1:0] head);
		return (head == HEAD_CW || head == HEAD_CCW) ? head : COIL_OFF;
	endfunction

endpackage

// ===== src/motor_speed_ramp_profiler.sv =====
// Trapezoidal speed ramp generator. Each accepted word (a tick or a command) yields exactly
// one result word, via the input register and then the output register; a new word can be
// accepted every cycle unless the output stalls. The whole update of speed, target, timer
// and coil state for one word is a single registered step between the two. Configuration
// writes are taken whenever the input register is empty and act on the drive state at once.
module motor_speed_ramp_profiler
	import msrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic    take, fire, busy;
	item_t   item_s1;
	result_t result_d;

	assign cfg_ready = !busy;

	msrp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.take       (take),
		.fire       (fire),
		.busy       (busy),
		.item_s1    (item_s1)
	);

	msrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result_d  (result_d)
	);

	msrp_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.result_d     (result_d),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== src/msrp_in_reg.sv =====
module msrp_in_reg
	import msrp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	input  logic  take,
	output logic  fire,
	output logic  busy,
	output item_t item_s1
);

	logic valid_s1;

	assign item_stall = valid_s1 && !take;
	assign fire       = valid_s1 && take;
	assign busy       = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== src/msrp_core.sv =====
module msrp_core
	import msrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  item_t       item_s1,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output result_t     result_d
);

	// Configuration registers that only feed later decisions.
	logic                  timed_run_q;
	logic [RUN_TIME_W-1:0] run_time_q;
	logic [14:0]           target_speed_q;

	// Drive state.
	logic                  running_q, pending_q, reached_q, timed_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic signed [15:0]    speed_q, target_q;
	logic [1:0]            heading_q, coil_q;
	logic [14:0]           step_q, duty_q;

	logic                  n_run, n_pend, n_reach, n_timed;
	logic [TIMER_BITS-1:0] n_el;
	logic signed [15:0]    n_speed, n_target;
	logic [1:0]            n_head, n_coil;
	logic [14:0]           n_step, n_duty, mag;
	logic                  may_update;
	logic signed [17:0]    sp, st, tg, sum, dif;

	always_comb begin
		n_run    = running_q;
		n_pend   = pending_q;
		n_reach  = reached_q;
		n_timed  = timed_q;
		n_el     = elapsed_q;
		n_speed  = speed_q;
		n_target = target_q;
		n_head   = heading_q;
		n_coil   = coil_q;
		n_step   = step_q;
		n_duty   = duty_q;
		mag      = '0;
		sp       = '0;
		st       = '0;
		tg       = '0;
		sum      = '0;
		dif      = '0;
		may_update = running_q && !timed_q;

		if (fire) begin
			case (item_s1.kind)
				KIND_TICK: begin
					if (n_el != {TIMER_BITS{1'b1}}) begin
						n_el = n_el + 1'b1;
					end
					if (n_run) begin
						if (n_pend) begin
							n_coil = coils_for(n_head);
							n_pend = 1'b0;
						end
						// A zero step jumps straight to the target.
						if (!n_reach && n_step == '0) begin
							n_duty  = magnitude(n_target);
							n_speed = n_target;
							n_reach = 1'b1;
							if (n_target != '0) begin
								n_el = '0;
							end else begin
								n_speed = '0;
								n_duty  = '0;
								n_coil  = COIL_OFF;
								n_run   = 1'b0;
								n_timed = 1'b0;
							end
						end
						if (!n_reach && n_step != '0 && n_el >= TIMER_BITS'(RAMP_PERIOD)) begin
							sp  = {{2{n_speed[15]}}, n_speed};
							tg  = {{2{n_target[15]}}, n_target};
							st  = {3'b000, n_step};
							sum = sp + st;
							dif = sp - st;
							if (sp < tg) begin
								// Crossing zero upward flips the coils to the heading.
								if (sp < 0 && sum >= 0) begin
									n_coil = coils_for(n_head);
								end
								if (sum >= tg) begin
									n_speed = n_target;
									n_reach = 1'b1;
								end else begin
									n_speed = sum[15:0];
								end
							end else if (sp > tg) begin
								if (sp >= 0 && dif <= 0) begin
									n_coil = coils_for(n_head);
								end
								if (dif <= tg) begin
									n_speed = n_target;
									n_reach = 1'b1;
									// A timed run ends when deceleration lands.
									if (n_timed) begin
										n_speed = '0;
										n_duty  = '0;
										n_coil  = COIL_OFF;
										n_run   = 1'b0;
										n_timed = 1'b0;
									end
								end else begin
									n_speed = dif[15:0];
								end
							end else begin
								n_reach = 1'b1;
							end
							n_duty = n_run ? magnitude(n_speed) : '0;
							n_el   = '0;
						end
						if (n_reach && n_timed && CMP_W'(n_el) >= CMP_W'(run_time_q)) begin
							n_target = '0;
							n_reach  = 1'b0;
							if (n_step != '0) begin
								n_el = '0;
							end
						end
					end
				end
				KIND_START: begin
					if ((n_head == HEAD_CW || n_head == HEAD_CCW) && n_target != '0 && !n_run) begin
						n_run   = 1'b1;
						n_pend  = 1'b1;
						n_reach = 1'b0;
						if (n_step != '0) begin
							n_el = '0;
						end
						n_timed = timed_run_q;
					end
				end
				KIND_STOP: begin
					n_speed = '0;
					n_duty  = '0;
					n_coil  = COIL_OFF;
					n_run   = 1'b0;
					n_timed = 1'b0;
				end
				KIND_NEW_SPEED: begin
					if (may_update) begin
						n_target = signed_by_heading(n_head, clamp_speed(item_s1.value));
						n_reach  = 1'b0;
						if (n_step != '0) begin
							n_el = '0;
						end
					end
				end
				KIND_NEW_STEP: begin
					if (may_update) begin
						n_step = item_s1.value;
					end
				end
				KIND_NEW_DIR: begin
					if (may_update && (item_s1.value == 15'(HEAD_CW)
							|| item_s1.value == 15'(HEAD_CCW))) begin
						if (n_head != item_s1.value[1:0]) begin
							mag      = magnitude(n_target);
							n_head   = item_s1.value[1:0];
							n_target = signed_by_heading(n_head, mag);
						end
						n_reach = 1'b0;
						if (n_step == '0) begin
							n_pend = 1'b1;
						end else begin
							n_el = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_DIRECTION: begin
					n_head   = cfg_data[1:0];
					n_target = signed_by_heading(n_head, clamp_speed(target_speed_q));
				end
				REG_TARGET_SPEED: begin
					n_target = signed_by_heading(n_head, clamp_speed(cfg_data[14:0]));
				end
				REG_RAMP_STEP: begin
					n_step = cfg_data[14:0];
				end
				default: begin
				end
			endcase
		end

		result_d.speed_now     = n_speed;
		result_d.duty          = n_duty;
		result_d.coil_polarity = n_coil;
		result_d.running       = n_run;
		result_d.on_target     = n_reach;
		result_d.timed_active  = n_timed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timed_run_q    <= 1'b0;
			run_time_q     <= '0;
			target_speed_q <= '0;
		end else if (cfg_we && !fire) begin
			if (cfg_index == REG_TARGET_SPEED) begin
				target_speed_q <= cfg_data[14:0];
			end
			if (cfg_index == REG_TIMED_RUN) begin
				timed_run_q <= cfg_data[0];
			end
			if (cfg_index == REG_RUN_TIME_MS) begin
				run_time_q <= cfg_data[RUN_TIME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pending_q <= 1'b0;
			reached_q <= 1'b0;
			timed_q   <= 1'b0;
			elapsed_q <= '0;
			speed_q   <= '0;
			target_q  <= '0;
			heading_q <= '0;
			coil_q    <= COIL_OFF;
			step_q    <= '0;
			duty_q    <= '0;
		end else begin
			running_q <= n_run;
			pending_q <= n_pend;
			reached_q <= n_reach;
			timed_q   <= n_timed;
			elapsed_q <= n_el;
			speed_q   <= n_speed;
			target_q  <= n_target;
			heading_q <= n_head;
			coil_q    <= n_coil;
			step_q    <= n_step;
			duty_q    <= n_duty;
		end
	end

endmodule

// ===== src/msrp_out_reg.sv =====
module msrp_out_reg
	import msrp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_d,
	output logic    take,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic valid_q;

	// The output register can take a new word when it is empty or being drained.
	assign take         = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (take && load) begin
			result <= result_d;
		end
	end

endmodule

// ===== test/motor_speed_ramp_profiler_tb.sv =====
module motor_speed_ramp_profiler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msrp_pkg::*;

	localparam logic [1:0] DIR_UNSET = 2'd0;
	localparam logic [1:0] DIR_BAD   = 2'd3;
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam logic [14:0] VALUE_ALL_ONES = 15'h7FFF;
	localparam longint unsigned MS_TICKS_MAX = (64'd1 << TIMER_BITS) - 64'd1;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_WORDS = 1600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item_word = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	motor_speed_ramp_profiler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Drive model: register copies and motion state.
	logic [14:0]      goal_setting = '0;
	bit               timed_setting = 1'b0;
	logic [31:0]      run_limit = '0;
	bit               run_active = 1'b0;
	bit               coil_due = 1'b0;
	bit               at_target = 1'b0;
	bit               timed_on = 1'b0;
	longint unsigned  ms_ticks = 0;
	int               speed_cur = 0;
	int               speed_goal = 0;
	logic [1:0]       heading_cur = DIR_UNSET;
	logic [14:0]      ramp_inc = '0;
	logic [1:0]       coil_cur = COIL_OFF;
	logic [14:0]      duty_cur = '0;

	result_t pending_status[$];
	int      mismatches = 0;
	int      stall_left = 0;
	bit      back_to_back = 1'b0;

	function automatic int pick_wait();
		return back_to_back ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [14:0] limit_speed(input logic [14:0] v);
		return (v > SPEED_MAX) ? SPEED_MAX : v;
	endfunction

	function automatic int goal_for_heading(input logic [14:0] mag);
		int m;
		m = mag;
		if (heading_cur == HEAD_CW) begin
			return m;
		end else if (heading_cur == HEAD_CCW) begin
			return -m;
		end
		return 0;
	endfunction

	function automatic logic [14:0] abs_speed(input int v);
		return (v < 0) ? 15'(-v) : 15'(v);
	endfunction

	function automatic void halt_drive();
		speed_cur = 0;
		duty_cur = '0;
		coil_cur = COIL_OFF;
		run_active = 1'b0;
	endfunction

	function automatic void energize_coils();
		coil_cur = (heading_cur == HEAD_CW || heading_cur == HEAD_CCW) ? heading_cur : COIL_OFF;
	endfunction

	function automatic void ramp_toward_goal();
		int st;
		st = ramp_inc;
		if (speed_cur < speed_goal) begin
			if (speed_cur < 0 && speed_cur + st >= 0) begin
				energize_coils();
			end
			speed_cur += st;
			if (speed_cur >= speed_goal) begin
				speed_cur = speed_goal;
				at_target = 1'b1;
			end
		end else if (speed_cur > speed_goal) begin
			if (speed_cur >= 0 && speed_cur - st <= 0) begin
				energize_coils();
			end
			speed_cur -= st;
			if (speed_cur <= speed_goal) begin
				speed_cur = speed_goal;
				at_target = 1'b1;
				// A timed run ends for good once the deceleration lands.
				if (timed_on) begin
					halt_drive();
					timed_on = 1'b0;
				end
			end
		end else begin
			at_target = 1'b1;
		end
	endfunction

	function automatic void advance_ms();
		if (ms_ticks < MS_TICKS_MAX) begin
			ms_ticks++;
		end
		if (!run_active) begin
			return;
		end
		if (coil_due) begin
			energize_coils();
			coil_due = 1'b0;
		end
		if (!at_target && ramp_inc == 0) begin
			duty_cur = abs_speed(speed_goal);
			speed_cur = speed_goal;
			at_target = 1'b1;
			if (speed_goal != 0) begin
				ms_ticks = 0;
			end else begin
				halt_drive();
				timed_on = 1'b0;
			end
		end
		if (!at_target && ramp_inc != 0 && ms_ticks >= RAMP_PERIOD) begin
			ramp_toward_goal();
			duty_cur = run_active ? abs_speed(speed_cur) : '0;
			ms_ticks = 0;
		end
		if (at_target && timed_on && ms_ticks >= run_limit) begin
			speed_goal = 0;
			at_target = 1'b0;
			if (ramp_inc != 0) begin
				ms_ticks = 0;
			end
		end
	endfunction

	function automatic result_t predict_status(input item_t w);
		bit      may_update;
		logic [14:0] mag;
		result_t r;
		may_update = run_active && !timed_on;
		case (w.kind)
			KIND_TICK: begin
				advance_ms();
			end
			KIND_START: begin
				if ((heading_cur == HEAD_CW || heading_cur == HEAD_CCW) && speed_goal != 0
						&& !run_active) begin
					run_active = 1'b1;
					coil_due = 1'b1;
					at_target = 1'b0;
					if (ramp_inc != 0) begin
						ms_ticks = 0;
					end
					timed_on = timed_setting;
				end
			end
			KIND_STOP: begin
				halt_drive();
				timed_on = 1'b0;
			end
			KIND_NEW_SPEED: begin
				if (may_update) begin
					speed_goal = goal_for_heading(limit_speed(w.value));
					at_target = 1'b0;
					if (ramp_inc != 0) begin
						ms_ticks = 0;
					end
				end
			end
			KIND_NEW_STEP: begin
				if (may_update) begin
					ramp_inc = w.value;
				end
			end
			KIND_NEW_DIR: begin
				if (may_update && (w.value == HEAD_CW || w.value == HEAD_CCW)) begin
					if (heading_cur != w.value[1:0]) begin
						mag = abs_speed(speed_goal);
						heading_cur = w.value[1:0];
						speed_goal = goal_for_heading(mag);
					end
					at_target = 1'b0;
					if (ramp_inc == 0) begin
						coil_due = 1'b1;
					end else begin
						ms_ticks = 0;
					end
				end
			end
			default: begin
			end
		endcase
		r.speed_now = speed_cur[15:0];
		r.duty = duty_cur;
		r.coil_polarity = coil_cur;
		r.running = run_active;
		r.on_target = at_target;
		r.timed_active = timed_on;
		return r;
	endfunction

	function automatic void apply_setting(input reg_index_t idx, input logic [31:0] data);
		case (idx)
			REG_START_DIRECTION: begin
				heading_cur = data[1:0];
				speed_goal = goal_for_heading(limit_speed(goal_setting));
			end
			REG_TARGET_SPEED: begin
				goal_setting = data[14:0];
				speed_goal = goal_for_heading(limit_speed(goal_setting));
			end
			REG_RAMP_STEP: begin
				ramp_inc = data[14:0];
			end
			REG_TIMED_RUN: begin
				timed_setting = data[0];
			end
			REG_RUN_TIME_MS: begin
				run_limit = data;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic item_t make_word(input logic [2:0] kind, input logic [14:0] value);
		item_t w;
		w.kind = kind;
		w.value = value;
		return w;
	endfunction

	task automatic check_field(input string name, input integer want, input integer got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result side: random stall after every word, checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pending_status.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time,
						result_word);
					mismatches++;
				end else begin
					check_field("speed_now", pending_status[0].speed_now, result_word.speed_now);
					check_field("duty", pending_status[0].duty, result_word.duty);
					check_field("coil_polarity", pending_status[0].coil_polarity,
						result_word.coil_polarity);
					check_field("running", pending_status[0].running, result_word.running);
					check_field("on_target", pending_status[0].on_target, result_word.on_target);
					check_field("timed_active", pending_status[0].timed_active,
						result_word.timed_active);
					void'(pending_status.pop_front());
				end
				stall_left = pick_wait();
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("FAIL motor_speed_ramp_profiler");
		$finish;
	end

	// Valid is left high on acceptance so that a following word can go out back to back;
	// every other caller lowers it first.
	task automatic send_word(input item_t w);
		int gap;
		gap = pick_wait();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item_word <= w;
		do @(posedge clk); while (item_stall);
		pending_status.push_back(predict_status(w));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_status.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, data);
	endtask

	task automatic configure(input logic [1:0] dir, input logic [14:0] goal,
			input logic [14:0] inc, input logic timed, input logic [31:0] run_ms);
		wait_idle();
		write_reg(REG_START_DIRECTION, 32'(dir));
		write_reg(REG_TARGET_SPEED, 32'(goal));
		write_reg(REG_RAMP_STEP, 32'(inc));
		write_reg(REG_TIMED_RUN, 32'(timed));
		write_reg(REG_RUN_TIME_MS, run_ms);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_start_refused();
		configure(DIR_UNSET, 15'd1000, 15'd0, 1'b0, 32'd0);
		send_word(make_word(KIND_START, 15'd0));
		send_word(make_word(KIND_NEW_SPEED, 15'd500));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_SPARE_A, 15'd0));
		send_word(make_word(KIND_SPARE_B, VALUE_ALL_ONES));
		configure(HEAD_CW, 15'd0, 15'd0, 1'b0, 32'd0);
		send_word(make_word(KIND_START, 15'd0));
	endtask

	// Zero ramp step: the speed jumps straight to the target on the next tick.
	task automatic test_immediate_jump();
		configure(HEAD_CW, VALUE_ALL_ONES, 15'd0, 1'b0, 32'hFFFF_FFFF);
		send_word(make_word(KIND_START, 15'd0));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_START, 15'd0));
		send_word(make_word(KIND_NEW_DIR, 15'(HEAD_CCW)));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_NEW_DIR, 15'(DIR_BAD)));
		send_word(make_word(KIND_NEW_SPEED, VALUE_ALL_ONES));
		send_word(make_word(KIND_NEW_STEP, VALUE_ALL_ONES));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_STOP, 15'd0));
	endtask

	task automatic test_timed_zero_run();
		configure(HEAD_CCW, SPEED_MAX, 15'd0, 1'b1, 32'd0);
		send_word(make_word(KIND_START, 15'd0));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_NEW_SPEED, 15'd100));
		send_word(make_word(KIND_TICK, 15'd0));
		send_word(make_word(KIND_TICK, 15'd0));
	endtask

	function automatic logic [1:0] pick_dir();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return DIR_UNSET;
		end else if (pick == 1) begin
			return DIR_BAD;
		end
		return pick[0] ? HEAD_CW : HEAD_CCW;
	endfunction

	function automatic logic [14:0] pick_speed();
		case ($urandom_range(0, 9))
			0: return 15'd0;
			1: return VALUE_ALL_ONES;
			2: return SPEED_MAX;
			3: return 15'($urandom_range(SPEED_MAX + 1, 32767));
			default: return 15'($urandom_range(1, SPEED_MAX));
		endcase
	endfunction

	// Steps are mostly a fraction of the target so that ramps finish within a run.
	function automatic logic [14:0] pick_step(input logic [14:0] goal);
		logic [14:0] lim;
		lim = limit_speed(goal);
		case ($urandom_range(0, 9))
			0, 1: return 15'd0;
			2: return VALUE_ALL_ONES;
			3: return 15'($urandom_range(1, 32767));
			default: begin
				if (lim < 15'd600) begin
					return 15'($urandom_range(100, 6000));
				end
				return 15'(lim / $urandom_range(1, 6));
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_run_time();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	function automatic item_t pick_run_word();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			return make_word(KIND_TICK, 15'd0);
		end else if (pick < 78) begin
			return make_word(KIND_NEW_SPEED, pick_speed());
		end else if (pick < 82) begin
			return make_word(KIND_NEW_STEP, 15'($urandom_range(0, 3)
				? $urandom_range(0, 8000) : $urandom_range(0, 32767)));
		end else if (pick < 89) begin
			return make_word(KIND_NEW_DIR, 15'($urandom_range(0, 4)
				? $urandom_range(1, 2) : $urandom_range(0, 32767)));
		end else if (pick < 92) begin
			return make_word(KIND_STOP, 15'($urandom_range(0, 32767)));
		end else if (pick < 96) begin
			return make_word(KIND_START, 15'($urandom_range(0, 32767)));
		end
		return make_word(3'($urandom_range(0, 7)), 15'($urandom_range(0, 32767)));
	endfunction

	// Each run: fresh settings, a start, then mostly ticks with commands mixed in.
	task automatic test_random_ramps();
		int sent;
		int run_len;
		logic [14:0] goal;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			back_to_back = ($urandom_range(0, 3) == 0);
			goal = pick_speed();
			configure(pick_dir(), goal, pick_step(goal), 1'($urandom_range(0, 1)),
				pick_run_time());
			if ($urandom_range(0, 2) == 0) begin
				send_word(make_word(KIND_STOP, 15'd0));
			end
			send_word(make_word(KIND_START, 15'd0));
			run_len = $urandom_range(60, 220);
			repeat (run_len) begin
				send_word(pick_run_word());
				if ($urandom_range(0, 149) == 0) begin
					wait_idle();
				end
			end
			sent += run_len + 1;
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_start_refused();
		test_immediate_jump();
		test_timed_zero_run();
		test_random_ramps();
		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("PASS motor_speed_ramp_profiler");
		end else begin
			$display("FAIL motor_speed_ramp_profiler");
		end
		$finish;
	end

endmodule
